[rtl/core/rcke_pkg.sv]
package rcke_pkg;

    // Field and register widths
    localparam int MAX_K      = 31;
    localparam int CODE_W     = 62;
    localparam int CHAR_W     = 8;
    localparam int GENOME_W   = 8;
    localparam int PART_W     = 8;
    localparam int K_W        = 5;
    localparam int PCOUNT_W   = 9;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_KMER_LENGTH     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CANONICAL_MODE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PARTITION_COUNT = 2'd2;

    // Reset values of the registers
    localparam logic [K_W-1:0]      KMER_LENGTH_RST     = 5'd21;
    localparam logic [PCOUNT_W-1:0] PARTITION_COUNT_RST = 9'd1;
    localparam logic [PCOUNT_W-1:0] PARTITION_MAX       = 9'd256;

    // ASCII characters of interest
    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;
    localparam logic [CHAR_W-1:0] CH_GAP  = 8'h2D;

    // Character classes; the four bases carry their 2-bit code in the low bits
    typedef enum logic [2:0] {
        CLS_A     = 3'b000,
        CLS_C     = 3'b001,
        CLS_G     = 3'b010,
        CLS_T     = 3'b011,
        CLS_GAP   = 3'b100,
        CLS_OTHER = 3'b101
    } base_cls_t;

    typedef struct packed {
        logic [K_W-1:0]      kmer_length;
        logic                canonical_mode;
        logic [PCOUNT_W-1:0] partition_count;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [GENOME_W-1:0] genome;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Map a character to its class.
    function automatic base_cls_t classify(input logic [CHAR_W-1:0] ch);
        base_cls_t cls;
        unique case (ch)
            CH_A_UP, CH_A_LO: cls = CLS_A;
            CH_C_UP, CH_C_LO: cls = CLS_C;
            CH_G_UP, CH_G_LO: cls = CLS_G;
            CH_T_UP, CH_T_LO: cls = CLS_T;
            CH_GAP:           cls = CLS_GAP;
            default:          cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // k as used by the datapath: zero acts as one, large values clamp.
    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        r = k;
        if (k == '0) r = K_W'(1);
        if (int'(k) > MAX_K) r = K_W'(MAX_K);
        return r;
    endfunction

    // Partition count as used by the divider: 1 to 256.
    function automatic logic [PCOUNT_W-1:0] eff_parts(input logic [PCOUNT_W-1:0] p);
        logic [PCOUNT_W-1:0] r;
        r = p;
        if (p == '0) r = PCOUNT_W'(1);
        if (p > PARTITION_MAX) r = PARTITION_MAX;
        return r;
    endfunction

    // Mask that keeps the low 2k bits of a code.
    function automatic logic [CODE_W-1:0] kmask(input logic [K_W-1:0] k);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < MAX_K; i++) begin
            m[2*i +: 2] = (i < int'(k)) ? 2'b11 : 2'b00;
        end
        return m;
    endfunction

    // Reverse complement of a k-base code whose upper bits are zero.
    function automatic logic [CODE_W-1:0] rev_comp(input logic [CODE_W-1:0] code,
                                                   input logic [K_W-1:0]    k);
        logic [CODE_W-1:0] r;
        for (int i = 0; i < MAX_K; i++) begin
            r[2*i +: 2] = ~code[2*(MAX_K-1-i) +: 2];
        end
        return r >> (2 * (MAX_K - int'(k)));
    endfunction

endpackage

[rtl/core/rcke_if.sv]
// Input channel: one sequence character per transaction.
interface rcke_in_if;
    import rcke_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   base_char;
    logic                sequence_start;
    logic [GENOME_W-1:0] genome_number;

    modport source (output valid, output base_char, output sequence_start,
                    output genome_number, input ready);
    modport sink   (input valid, input base_char, input sequence_start,
                    input genome_number, output ready);
endinterface

// Output channel: one k-mer result per transaction.
interface rcke_out_if;
    import rcke_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   kmer_code;
    logic [PART_W-1:0]   partition_index;
    logic [GENOME_W-1:0] genome_tag;

    modport source (output valid, output kmer_code, output partition_index,
                    output genome_tag, input ready);
    modport sink   (input valid, input kmer_code, input partition_index,
                    input genome_tag, output ready);
endinterface

[rtl/core/rcke_cfg.sv]
module rcke_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcke_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcke_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcke_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output rcke_pkg::cfg_t                 cfg
);
    import rcke_pkg::*;

    logic [K_W-1:0]       kmer_length_reg;
    logic                 canonical_mode_reg;
    logic [PCOUNT_W-1:0]  partition_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Registers sit on word addresses; the byte offset is ignored.
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg     <= KMER_LENGTH_RST;
            canonical_mode_reg  <= 1'b0;
            partition_count_reg <= PARTITION_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KMER_LENGTH:     kmer_length_reg     <= pwdata[K_W-1:0];
                REG_CANONICAL_MODE:  canonical_mode_reg  <= pwdata[0];
                REG_PARTITION_COUNT: partition_count_reg <= pwdata[PCOUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_KMER_LENGTH:     prdata = APB_DATA_W'(kmer_length_reg);
            REG_CANONICAL_MODE:  prdata = APB_DATA_W'(canonical_mode_reg);
            REG_PARTITION_COUNT: prdata = APB_DATA_W'(partition_count_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.kmer_length     = kmer_length_reg;
    assign cfg.canonical_mode  = canonical_mode_reg;
    assign cfg.partition_count = partition_count_reg;

endmodule

[rtl/core/rcke_front.sv]
module rcke_front (
    input  logic                clk,
    input  logic                rst_n,
    rcke_in_if.sink             seq_in,
    input  rcke_pkg::cfg_t      cfg,
    input  rcke_pkg::q_status_t q_status,
    output logic                push,
    output rcke_pkg::entry_t    push_entry
);
    import rcke_pkg::*;

    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [K_W-1:0]    count_reg;
    logic [K_W-1:0]    count_next;

    logic              accept;
    base_cls_t         cls;
    logic [K_W-1:0]    k;
    logic [CODE_W-1:0] code_base;
    logic [K_W-1:0]    count_base;
    logic [K_W:0]      count_sum;
    logic [CODE_W-1:0] code_shift;
    logic              is_base;

    // Items are taken while the queue has room for a possible result.
    assign seq_in.ready = !q_status.full;
    assign accept       = seq_in.valid && seq_in.ready;

    assign cls = classify(seq_in.base_char);
    assign k   = eff_k(cfg.kmer_length);

    // A sequence start clears the history before this character is used.
    assign code_base  = seq_in.sequence_start ? '0 : code_reg;
    assign count_base = seq_in.sequence_start ? '0 : count_reg;
    assign code_shift = {code_base[CODE_W-3:0], 2'(cls)};
    assign count_sum  = {1'b0, count_base} + (K_W+1)'(1);
    assign is_base    = (cls == CLS_A) || (cls == CLS_C) || (cls == CLS_G) || (cls == CLS_T);

    // Next rolling state
    always_comb
    begin
        code_next  = code_reg;
        count_next = count_reg;
        if (accept)
        begin
            priority if (is_base)
            begin
                code_next  = code_shift;
                count_next = (count_sum > {1'b0, k}) ? k : count_sum[K_W-1:0];
            end
            else if (cls == CLS_GAP)
            begin
                code_next  = code_base;
                count_next = count_base;
            end
            else
            begin
                code_next  = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            code_reg  <= code_next;
            count_reg <= count_next;
        end
    end

    // A full window of k bases hands a k-mer to the back end.
    assign push              = accept && is_base && (count_sum >= {1'b0, k});
    assign push_entry.code   = code_shift & kmask(k);
    assign push_entry.genome = seq_in.genome_number;

endmodule

[rtl/core/rcke_queue.sv]
module rcke_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rcke_pkg::entry_t    push_entry,
    input  logic                pop,
    output rcke_pkg::entry_t    head,
    output rcke_pkg::q_status_t status
);
    import rcke_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Pointer and fill-level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[rtl/core/rcke_back.sv]
module rcke_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rcke_pkg::cfg_t      cfg,
    input  rcke_pkg::q_status_t q_status,
    input  rcke_pkg::entry_t    head,
    output logic                pop,
    rcke_out_if.source          kmer_out
);
    import rcke_pkg::*;

    localparam int DIV_STEPS = CODE_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PICK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [CODE_W-1:0]   code_reg;
    logic [CODE_W-1:0]   code_next;
    logic [CODE_W-1:0]   rc_reg;
    logic [CODE_W-1:0]   rc_next;
    logic [GENOME_W-1:0] genome_reg;
    logic [GENOME_W-1:0] genome_next;
    logic [CODE_W-1:0]   div_reg;
    logic [CODE_W-1:0]   div_next;
    logic [PART_W-1:0]   rem_reg;
    logic [PART_W-1:0]   rem_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CODE_W-1:0]   out_code_reg;
    logic [PART_W-1:0]   out_part_reg;
    logic [GENOME_W-1:0] out_genome_reg;

    logic [K_W-1:0]      k;
    logic [PCOUNT_W-1:0] parts;
    logic [CODE_W-1:0]   picked;
    logic [PCOUNT_W-1:0] part1;
    logic [PCOUNT_W-1:0] part1_red;
    logic [PCOUNT_W-1:0] part2;
    logic [PCOUNT_W-1:0] part2_red;
    logic                out_free;
    logic                out_load;

    assign k      = eff_k(cfg.kmer_length);
    assign parts  = eff_parts(cfg.partition_count);
    assign picked = (cfg.canonical_mode && (rc_reg < code_reg)) ? rc_reg : code_reg;

    // Two restoring remainder steps per cycle; the remainder stays below the divisor.
    assign part1     = {rem_reg, div_reg[CODE_W-1]};
    assign part1_red = (part1 >= parts) ? part1 - parts : part1;
    assign part2     = {part1_red[PART_W-1:0], div_reg[CODE_W-2]};
    assign part2_red = (part2 >= parts) ? part2 - parts : part2;

    // The output register frees up when its transaction completes.
    assign out_free = !out_valid_reg || kmer_out.ready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        rc_next        = rc_reg;
        genome_next    = genome_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (kmer_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    code_next   = head.code;
                    rc_next     = rev_comp(head.code, k);
                    genome_next = head.genome;
                    state_next  = ST_PICK;
                end
            end
            ST_PICK:
            begin
                code_next  = picked;
                div_next   = picked;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_next  = {div_reg[CODE_W-3:0], 2'b00};
                rem_next  = part2_red[PART_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        rc_reg     <= rc_next;
        genome_reg <= genome_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        if (out_load)
        begin
            out_code_reg   <= code_reg;
            out_part_reg   <= rem_reg;
            out_genome_reg <= genome_reg;
        end
    end

    assign kmer_out.valid           = out_valid_reg;
    assign kmer_out.kmer_code       = out_code_reg;
    assign kmer_out.partition_index = out_part_reg;
    assign kmer_out.genome_tag      = out_genome_reg;

endmodule

[rtl/core/rolling_canonical_kmer_extractor.sv]
// Rolling k-mer extractor. Each input transaction carries one ASCII character of an
// aligned sequence; bases A, C, G and T (either case) are shifted into a 2-bit rolling
// code, '-' is skipped, any other character or a sequence start restarts the window.
// Once k bases are held, every further base yields one output transaction with the k-mer
// (first base most significant, or the smaller of it and its reverse complement in
// canonical mode), its remainder modulo the partition count and the genome number.
// The front end takes one character per cycle while the result queue has room; a
// character that completes a k-mer occupies the back end, which takes no new k-mer
// until it is done: it loads the entry, picks the canonical form, reckons the remainder
// at two bits per cycle and hands the result to the output register once it is free.
// Configuration must be written over the APB port only while no transaction is in
// flight; the block itself does not enforce this.
module rolling_canonical_kmer_extractor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcke_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcke_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcke_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    rcke_in_if.sink                         seq_in,
    rcke_out_if.source                      kmer_out
);
    import rcke_pkg::*;

    cfg_t      cfg;
    q_status_t q_status;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;

    // Register file
    rcke_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Character classification and rolling window
    rcke_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_in     (seq_in),
        .cfg        (cfg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue of k-mers awaiting the back end
    rcke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Canonical selection, partition remainder and output register
    rcke_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .kmer_out (kmer_out)
    );

    // The partition index is always below the effective partition count.
    assert property (@(posedge clk) disable iff (!rst_n)
        kmer_out.valid |->
            ({1'b0, kmer_out.partition_index} < eff_parts(cfg.partition_count)))
        else $error("partition index not below partition count");

    // A result never carries bases beyond the k-base window.
    assert property (@(posedge clk) disable iff (!rst_n)
        kmer_out.valid |->
            ((kmer_out.kmer_code & ~kmask(eff_k(cfg.kmer_length))) == '0))
        else $error("k-mer code wider than 2k bits");

    // In canonical mode a result is never larger than its reverse complement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (kmer_out.valid && cfg.canonical_mode) |->
            (kmer_out.kmer_code <= rev_comp(kmer_out.kmer_code, eff_k(cfg.kmer_length))))
        else $error("canonical k-mer larger than its reverse complement");

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

endmodule
